// ===== src/ttbe_pkg.sv =====
// shared types and constants for the tap tempo bpm estimator
// used by the channel interfaces and every module of the block
package ttbe_pkg;

  localparam int WINDOW  = 5;
  localparam int DIVISOR = WINDOW - 1;

  localparam int SAMPLE_W = 10;
  localparam int TS_W     = 16;
  localparam int THR_W    = 10;
  localparam int DEB_W    = 16;
  localparam int TPM_W    = 24;
  localparam int BPM_W    = 16;
  localparam int AVG_W    = TS_W;

  localparam int SEEN_W = $clog2(WINDOW + 1);
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(TPM_W + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd1;
  localparam logic [1:0] REG_TPM       = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(500);
  localparam logic [DEB_W-1:0] DEBOUNCE_RST  = DEB_W'(2000);
  localparam logic [TPM_W-1:0] TPM_RST       = TPM_W'(937500);

  // work handed from the front to the divider side
  typedef struct packed {
    logic             beat;
    logic             need_div;
    logic [AVG_W-1:0] avg;
    logic [TPM_W-1:0] tpm;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } back_state_t;

endpackage

// ===== src/ttbe_if.sv =====
// valid/ready channel interfaces for samples in and tempo results out
// depends on ttbe_pkg for field widths
interface ttbe_in_if;
  import ttbe_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [TS_W-1:0]     timestamp;
  modport source (output valid, sample, timestamp, input ready);
  modport sink   (input valid, sample, timestamp, output ready);
endinterface

interface ttbe_out_if;
  import ttbe_pkg::*;
  logic             valid;
  logic             ready;
  logic             beat;
  logic             tempo_valid;
  logic [BPM_W-1:0] tempo_bpm;
  modport source (output valid, beat, tempo_valid, tempo_bpm, input ready);
  modport sink   (input valid, beat, tempo_valid, tempo_bpm, output ready);
endinterface

// ===== src/ttbe_front.sv =====
// front end: takes samples, detects and debounces beats, keeps the beat window
// and forms the average interval; depends on ttbe_pkg and ttbe_in_if
module ttbe_front (
  input  logic                      clk,
  input  logic                      rst_n,
  ttbe_in_if.sink                   in_ch,
  input  logic [ttbe_pkg::THR_W-1:0] thr,
  input  logic [ttbe_pkg::DEB_W-1:0] deb,
  input  logic [ttbe_pkg::TPM_W-1:0] tpm,
  input  logic                      q_full,
  output logic                      push,
  output ttbe_pkg::job_t            job
);
  import ttbe_pkg::*;

  logic [TS_W-1:0]   times_r [WINDOW];
  logic [TS_W-1:0]   last_r;
  logic [SEEN_W-1:0] seen_r;

  logic [TS_W-1:0]  gap;
  logic [TS_W-1:0]  oldest;
  logic [TS_W-1:0]  span;
  logic [AVG_W-1:0] avg;
  logic             is_beat;
  logic             full_after;
  logic             win_full;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign gap = (in_ch.timestamp >= last_r) ? in_ch.timestamp - last_r
                                           : last_r - in_ch.timestamp;
  assign is_beat = (in_ch.sample > thr) &&
                   ((seen_r == '0) || (gap >= deb));

  assign win_full   = (seen_r == SEEN_W'(WINDOW));
  assign full_after = (seen_r >= SEEN_W'(WINDOW - 1));
  // once full, the entry at slot one becomes the oldest after the shift
  assign oldest = win_full ? times_r[1] : times_r[0];
  assign span   = in_ch.timestamp - oldest;
  assign avg    = AVG_W'(span / DIVISOR);

  always_comb begin
    job.beat     = is_beat;
    job.need_div = is_beat && full_after && (avg != '0);
    job.avg      = avg;
    job.tpm      = tpm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (push && is_beat && !win_full) begin
      seen_r <= seen_r + SEEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && is_beat) begin
      last_r <= in_ch.timestamp;
      if (win_full) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          times_r[i] <= times_r[i+1];
        end
        times_r[WINDOW-1] <= in_ch.timestamp;
      end else begin
        times_r[seen_r[IDX_W-1:0]] <= in_ch.timestamp;
      end
    end
  end

endmodule

// ===== src/ttbe_queue.sv =====
// short job queue between the beat front end and the divider back end
// depends on ttbe_pkg for job_t and the depth
module ttbe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttbe_pkg::job_t push_job,
  input  logic           pop,
  output ttbe_pkg::job_t pop_job,
  output logic           empty,
  output logic           full
);
  import ttbe_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_job = mem_r[rptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= ptr_inc(wptr_r);
      if (pop)  rptr_r <= ptr_inc(rptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== src/ttbe_back.sv =====
// back end: restoring radix-2 divider for ticks-per-minute / interval and
// the result output register; depends on ttbe_pkg and ttbe_out_if
module ttbe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ttbe_pkg::job_t q_job,
  output logic           pop,
  ttbe_out_if.source     out_ch
);
  import ttbe_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [AVG_W-1:0] div_r;
  logic [AVG_W-1:0] rem_r, rem_nxt;
  logic [TPM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic             ovalid_r;
  logic             obeat_r;
  logic             otv_r;
  logic [BPM_W-1:0] obpm_r;

  logic           out_free;
  logic           div_done;
  logic           load_plain;
  logic           load_div;
  logic [AVG_W:0] trial;
  logic [BPM_W-1:0] sat_q;

  assign out_free = !ovalid_r || out_ch.ready;
  assign div_done = (state_r == S_DIV) && (cnt_r == CNT_W'(TPM_W));

  assign load_div   = (state_r == S_IDLE) && !q_empty && q_job.need_div;
  assign load_plain = (state_r == S_IDLE) && !q_empty && !q_job.need_div && out_free;
  assign pop        = load_div || load_plain;

  // one quotient bit per cycle, dividend shifts out of the top of quo_r
  assign trial = {rem_r, quo_r[TPM_W-1]};
  always_comb begin
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = AVG_W'(trial - {1'b0, div_r});
      quo_nxt = {quo_r[TPM_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[AVG_W-1:0];
      quo_nxt = {quo_r[TPM_W-2:0], 1'b0};
    end
  end

  assign sat_q = (|quo_r[TPM_W-1:BPM_W]) ? '1 : quo_r[BPM_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (load_div) state_nxt = S_DIV;
      S_DIV:   if (div_done && out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_plain || (div_done && out_free)) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_div) begin
      div_r <= q_job.avg;
      rem_r <= '0;
      quo_r <= q_job.tpm;
      cnt_r <= '0;
    end else if ((state_r == S_DIV) && !div_done) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_plain) begin
      obeat_r <= q_job.beat;
      otv_r   <= 1'b0;
      obpm_r  <= '0;
    end else if (div_done && out_free) begin
      obeat_r <= 1'b1;
      otv_r   <= 1'b1;
      obpm_r  <= sat_q;
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.beat        = obeat_r;
  assign out_ch.tempo_valid = otv_r;
  assign out_ch.tempo_bpm   = obpm_r;

endmodule

// ===== src/tap_tempo_bpm_estimator.sv =====
// top level of the tap tempo bpm estimator: config registers, front end,
// job queue and divider back end; depends on ttbe_pkg and ttbe_if
//
// in_ch carries one pressure sample and its tick timestamp per transfer; out_ch
// returns exactly one result per sample: beat flag, tempo_valid, tempo_bpm.
// the apb port holds beat_threshold (0x0), debounce_ticks (0x4) and
// ticks_per_minute (0x8); write only while no sample is in flight.
// the front end classifies a sample in the cycle it is taken; a sample with
// no tempo to compute passes through the job queue and the output register.
// a beat with a full window and a nonzero average interval runs a 24-step
// restoring divider whose result is loaded into the output register; the
// single shared divider starts no new division until that result is loaded.
// a two-entry queue sits between front and divider, so samples keep being
// taken while a division runs until the queue fills; in_ch.ready drops then.
// if out_ch stalls the result holds in the output register, the divider
// waits, and the queue backs up into in_ch.
// reset (rst_n low, synchronous) empties the window, the queue and the
// output and loads the register defaults 500, 2000 and 937500.
module tap_tempo_bpm_estimator (
  input  logic                        clk,
  input  logic                        rst_n,
  ttbe_in_if.sink                     in_ch,
  ttbe_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttbe_pkg::ADDR_W-1:0] paddr,
  input  logic [ttbe_pkg::DATA_W-1:0] pwdata,
  output logic [ttbe_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import ttbe_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [DEB_W-1:0] deb_r;
  logic [TPM_W-1:0] tpm_r;
  logic             wr_en;
  logic [1:0]       reg_sel;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t pop_job;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
      deb_r <= DEBOUNCE_RST;
      tpm_r <= TPM_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_THRESHOLD: thr_r <= pwdata[THR_W-1:0];
        REG_DEBOUNCE:  deb_r <= pwdata[DEB_W-1:0];
        REG_TPM:       tpm_r <= pwdata[TPM_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = DATA_W'(thr_r);
      REG_DEBOUNCE:  prdata = DATA_W'(deb_r);
      REG_TPM:       prdata = DATA_W'(tpm_r);
      default:       prdata = '0;
    endcase
  end

  ttbe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .thr    (thr_r),
    .deb    (deb_r),
    .tpm    (tpm_r),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  ttbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  ttbe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("job queue read while empty");

  a_tempo_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.tempo_valid) |-> out_ch.beat)
    else $error("tempo reported without a beat");

  a_idle_bpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.tempo_valid) |-> (out_ch.tempo_bpm == '0))
    else $error("bpm nonzero without a valid tempo");
`endif

endmodule

// ===== bench/ttbe_tempo_checker.sv =====
// tempo checker: watches the sample and result channels and the apb writes,
// predicts each result and compares it with what the estimator returns
// depends on ttbe_pkg and the channel interfaces in ttbe_if
module ttbe_tempo_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  ttbe_in_if                          in_ch,
  ttbe_out_if                         out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ttbe_pkg::ADDR_W-1:0] paddr,
  input  logic [ttbe_pkg::DATA_W-1:0] pwdata,
  output int                          pending,
  output int                          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttbe_pkg::*;

  typedef struct packed {
    logic             beat;
    logic             tempo_valid;
    logic [BPM_W-1:0] tempo_bpm;
  } tempo_t;

  tempo_t           tempo_q[$];
  logic [TS_W-1:0]  tap_times[WINDOW];
  int unsigned      taps_held;
  logic [THR_W-1:0] thr;
  logic [DEB_W-1:0] deb;
  logic [TPM_W-1:0] tpm;
  int               n_bad = 0;

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("tempo check: %s got %0d want %0d at %0t", field, got, want, $time);
    n_bad++;
  endtask

  // classify one sample, update the tap window and work out the tempo
  function automatic tempo_t next_tempo(input logic [SAMPLE_W-1:0] s,
                                        input logic [TS_W-1:0] ts);
    tempo_t           r;
    logic [TS_W-1:0]  last;
    logic [TS_W-1:0]  gap;
    logic [TS_W-1:0]  span;
    logic [AVG_W-1:0] avg;
    logic [TPM_W-1:0] quo;
    logic             take;
    r = '0;
    if (s > thr) begin
      take = 1'b1;
      if (taps_held > 0) begin
        last = tap_times[taps_held - 1];
        // plain distance, no wraparound
        gap = (ts >= last) ? ts - last : last - ts;
        if (gap < deb) take = 1'b0;
      end
      if (take) begin
        r.beat = 1'b1;
        if (taps_held < WINDOW) begin
          tap_times[taps_held] = ts;
          taps_held++;
        end else begin
          for (int i = 0; i < WINDOW - 1; i++) tap_times[i] = tap_times[i + 1];
          tap_times[WINDOW - 1] = ts;
        end
        if (taps_held == WINDOW) begin
          // span wraps modulo the timestamp width
          span = tap_times[WINDOW - 1] - tap_times[0];
          avg  = span / DIVISOR;
          if (avg != 0) begin
            quo = tpm / avg;
            r.tempo_valid = 1'b1;
            r.tempo_bpm   = (quo > TPM_W'(16'hFFFF)) ? 16'hFFFF : quo[BPM_W-1:0];
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tempo_t want;
    if (!rst_n) begin
      tempo_q.delete();
      for (int i = 0; i < WINDOW; i++) tap_times[i] = '0;
      taps_held = 0;
      thr = THRESHOLD_RST;
      deb = DEBOUNCE_RST;
      tpm = TPM_RST;
    end else begin
      // results first: a sample taken at this edge cannot answer at it
      if (out_ch.valid && out_ch.ready) begin
        if (tempo_q.size() == 0) begin
          report_mismatch("result with nothing pending, bpm", out_ch.tempo_bpm, 0);
        end else begin
          want = tempo_q.pop_front();
          if (out_ch.beat !== want.beat)
            report_mismatch("beat", out_ch.beat, want.beat);
          if (out_ch.tempo_valid !== want.tempo_valid)
            report_mismatch("tempo_valid", out_ch.tempo_valid, want.tempo_valid);
          if (out_ch.tempo_bpm !== want.tempo_bpm)
            report_mismatch("tempo_bpm", out_ch.tempo_bpm, want.tempo_bpm);
        end
      end
      if (in_ch.valid && in_ch.ready)
        tempo_q.push_back(next_tempo(in_ch.sample, in_ch.timestamp));
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_THRESHOLD: thr = pwdata[THR_W-1:0];
          REG_DEBOUNCE:  deb = pwdata[DEB_W-1:0];
          REG_TPM:       tpm = pwdata[TPM_W-1:0];
          default: ;
        endcase
      end
    end
    pending    <= tempo_q.size();
    fail_count <= n_bad;
  end

endmodule

// ===== bench/tb_tap_tempo_bpm_estimator.sv =====
// testbench top for the tap tempo bpm estimator: clock, reset, apb setup,
// tap-like sample stimulus with random idling and result stalls; verdict from ttbe_tempo_checker
// depends on ttbe_pkg, ttbe_if, the estimator rtl and ttbe_tempo_checker
module tb_tap_tempo_bpm_estimator;
  timeunit 1ns;
  timeprecision 1ps;
  import ttbe_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int N_PHASES        = 16;
  localparam int ITEMS_PER_PHASE = 108;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int               idle_pct = 0;
  int               stall_pct = 0;
  int               pending;
  int               fail_count;
  int               quiet_cycles = 0;
  logic [THR_W-1:0] cur_thr = THRESHOLD_RST;
  logic [DEB_W-1:0] cur_deb = DEBOUNCE_RST;
  logic [TS_W-1:0]  tap_clock = '0;

  ttbe_in_if  in_if ();
  ttbe_out_if out_if ();

  tap_tempo_bpm_estimator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ttbe_tempo_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side stalls at random, one decision per cycle
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // counts cycles with no transfer on either channel, fails the run at WATCHDOG_LIMIT
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // all tasks below start and end just after a falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [TS_W-1:0] ts);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample    <= s;
    in_if.timestamp <= ts;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_THRESHOLD: cur_thr = val[THR_W-1:0];
      REG_DEBOUNCE:  cur_deb = val[DEB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_tempo(input logic [THR_W-1:0] t, input logic [DEB_W-1:0] d,
                               input logic [TPM_W-1:0] m);
    wait_drained();
    write_reg(REG_THRESHOLD, DATA_W'(t));
    write_reg(REG_DEBOUNCE, DATA_W'(d));
    write_reg(REG_TPM, DATA_W'(m));
  endtask

  function automatic logic [SAMPLE_W-1:0] loud_sample();
    if (cur_thr == 10'h3FF) return 10'h3FF;
    return SAMPLE_W'($urandom_range(1023, cur_thr + 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] quiet_sample();
    return SAMPLE_W'($urandom_range(cur_thr, 0));
  endfunction

  // a tap-like stream: taps near the period, bounces, quiet samples, noise
  task automatic tap_item(input int period);
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) begin
      send_sample(SAMPLE_W'($urandom_range(1023)), TS_W'($urandom_range(65535)));
    end else if (roll < 45) begin
      send_sample(quiet_sample(), tap_clock + TS_W'($urandom_range(period)));
    end else if (roll < 57) begin
      send_sample(loud_sample(), tap_clock + TS_W'($urandom_range(period / 8)));
    end else begin
      tap_clock += TS_W'(period - period / 8 + $urandom_range(period / 4));
      send_sample(loud_sample(), tap_clock);
    end
  endtask

  task automatic run_phase(input int p);
    logic [THR_W-1:0] t;
    logic [DEB_W-1:0] d;
    logic [TPM_W-1:0] m;
    int               period;
    t = THR_W'($urandom_range(900, 100));
    d = DEB_W'($urandom_range(2500));
    m = ($urandom_range(1)) ? TPM_W'($urandom_range(1875000, 468750))
                            : TPM_W'($urandom_range(24'hFFFFFF, 1));
    case (p)
      0: begin t = '0; d = '0; m = TPM_W'(1); end
      1: begin t = 10'h3FF; d = 16'hFFFF; m = 24'hFFFFFF; end
      2: begin d = DEB_W'(1); m = 24'hFFFFFF; end
      3: m = '0;
      4: d = 16'hFFFF;
      5: t = 10'h3FE;
      default: ;
    endcase
    program_tempo(t, d, m);
    if (p == 4) write_reg(REG_SPARE, $urandom);
    idle_pct  = (p % 4 == 1) ? 63 : (p % 4 == 3) ? 26 : 0;
    stall_pct = (p % 4 == 2) ? 63 : (p % 4 == 3) ? 26 : 0;
    period = cur_deb + ((p % 2 == 1) ? $urandom_range(300, 4) : $urandom_range(4000, 200));
    repeat (ITEMS_PER_PHASE) tap_item(period);
  endtask

  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.sample    = '0;
    in_if.timestamp = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: threshold edge, first tap, debounce edge, raw distance
    send_sample(10'd0, 16'd0);
    send_sample(10'd500, 16'd100);
    send_sample(10'd501, 16'd100);
    send_sample(10'd1023, 16'd2099);
    send_sample(10'd1023, 16'd2100);
    send_sample(10'd700, 16'hFFFF);
    send_sample(10'd700, 16'd0);
    send_sample(10'd800, 16'd4000);
    send_sample(10'd1023, 16'd3000);
    send_sample(10'd1023, 16'd6000);

    // saturated tempo, then a zero average interval
    program_tempo(THRESHOLD_RST, '0, 24'hFFFFFF);
    send_sample(10'd501, 16'd10);
    send_sample(10'd501, 16'd11);
    send_sample(10'd501, 16'd12);
    send_sample(10'd501, 16'd13);
    send_sample(10'd501, 16'd14);
    send_sample(10'd501, 16'd14);

    // zero numerator still gives a valid tempo
    program_tempo(THRESHOLD_RST, '0, '0);
    send_sample(10'd501, 16'd20);

    for (int p = 0; p < N_PHASES; p++) run_phase(p);

    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ttbe_pkg.sv
src/ttbe_if.sv
src/ttbe_front.sv
src/ttbe_queue.sv
src/ttbe_back.sv
src/tap_tempo_bpm_estimator.sv
bench/ttbe_tempo_checker.sv
bench/tb_tap_tempo_bpm_estimator.sv
